/* rtl/rpn_pkg.sv */
// Shared types and constants for the RPN stack evaluator.
`default_nettype none

package rpn_pkg;

   // Q16.16 value and command widths
   localparam int Q_W    = 32;
   localparam int FRAC_W = 16;
   localparam int CMD_W  = 3;
   // dividend width of the fixed-point divide: value shifted up by the fraction bits
   localparam int DIV_W  = Q_W + FRAC_W;

   typedef enum logic [CMD_W-1:0] {
      CMD_PUSH     = 3'd0,
      CMD_ADD      = 3'd1,
      CMD_SUB      = 3'd2,
      CMD_MUL      = 3'd3,
      CMD_DIV      = 3'd4,
      CMD_REM      = 3'd5,
      CMD_PRINT    = 3'd6,
      CMD_UNKNOWN  = 3'd7
   } cmd_type;

   // controller to datapath
   typedef struct packed {
      logic    load;       // capture request, clear flags
      logic    push;       // write result register to top of stack
      logic    pop;        // read top of stack, decrement pointer
      logic    cap_b;      // take popped value as right operand
      logic    cap_a;      // take popped value as left operand
      logic    exec;       // add/subtract result, or register the product
      logic    div_start;  // launch the divider
      logic    mul_fix;    // scale and saturate the product
      logic    div_fix;    // sign and saturate divider outputs
      logic    set_zdiv;   // flag a zero divisor
      logic    emit;       // load the response register
      cmd_type op;
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic b_next_zero;   // value being captured as right operand is zero
      logic b_zero;        // right operand register is zero
      logic div_done;      // divider finished
   } dp_stat_type;

endpackage

`default_nettype wire

/* rtl/rpn_div.sv */
// Bit-serial restoring divider, one quotient bit per cycle.
`default_nettype none

module rpn_div (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   input  wire logic [rpn_pkg::DIV_W-1:0] dividend,
   input  wire logic [rpn_pkg::Q_W-1:0]   divisor,
   output logic                           done,
   output logic [rpn_pkg::DIV_W-1:0]      quotient,
   output logic [rpn_pkg::Q_W-1:0]        remainder
);
   import rpn_pkg::*;

   localparam int CNT_W = $clog2(DIV_W);

   logic [DIV_W-1:0] quo_ff;
   logic [Q_W-1:0]   rem_ff;
   logic [Q_W-1:0]   dsr_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             busy_ff;
   logic             done_ff;

   logic [Q_W:0]     partial;
   logic [Q_W+1:0]   diff;
   logic             borrow;

   // trial subtract of the shifted partial remainder
   assign partial = {rem_ff, quo_ff[DIV_W-1]};
   assign diff    = {1'b0, partial} - {2'b00, dsr_ff};
   assign borrow  = diff[Q_W+1];

   // control: busy for DIV_W steps, done pulses once
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(DIV_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // datapath: shift in one quotient bit a step
   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         dsr_ff <= divisor;
      end else if (busy_ff) begin
         quo_ff <= {quo_ff[DIV_W-2:0], ~borrow};
         rem_ff <= borrow ? partial[Q_W-1:0] : diff[Q_W-1:0];
      end
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

`default_nettype wire

/* rtl/rpn_dpath.sv */
// Datapath: value stack memory, operand registers, arithmetic and response register.
`default_nettype none

module rpn_dpath #(
   parameter int STACK_DEPTH = 128
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire rpn_pkg::dp_cmd_type     dp_cmd,
   output rpn_pkg::dp_stat_type         dp_stat,
   input  wire logic [rpn_pkg::Q_W-1:0] req_operand_value,
   output logic                         rsp_printed,
   output logic [rpn_pkg::Q_W-1:0]      rsp_print_value,
   output logic                         rsp_stack_full_error,
   output logic                         rsp_stack_empty_error,
   output logic                         rsp_zero_divisor_error,
   output logic                         rsp_unknown_command_error,
   output logic                         rsp_overflow_saturated
);
   import rpn_pkg::*;

   localparam int IDX_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int PTR_W = $clog2(STACK_DEPTH + 1);

   typedef struct packed {
      logic           ovf;
      logic [Q_W-1:0] val;
   } sat_type;

   // clamp a wide signed value to Q16.16
   function automatic sat_type sat_q(input logic [DIV_W:0] v);
      sat_type r;
      r.ovf = !((&v[DIV_W:Q_W-1]) || !(|v[DIV_W:Q_W-1]));
      if (r.ovf) begin
         r.val = v[DIV_W] ? {1'b1, {(Q_W-1){1'b0}}} : {1'b0, {(Q_W-1){1'b1}}};
      end else begin
         r.val = v[Q_W-1:0];
      end
      return r;
   endfunction

   // stack storage, contents undefined until written
   logic [Q_W-1:0]   stack_mem [STACK_DEPTH];
   logic [Q_W-1:0]   rd_data_ff;
   logic [PTR_W-1:0] sp_ff;
   logic [PTR_W-1:0] sp_dec;
   logic             pop_hit_ff;
   logic [Q_W-1:0]   popped;

   // operands and intermediate results
   logic [Q_W-1:0]   a_ff;
   logic [Q_W-1:0]   b_ff;
   logic [Q_W-1:0]   res_ff;
   logic [2*Q_W-1:0] prod_ff;

   // per-request flags
   logic full_ff;
   logic empty_ff;
   logic sat_ff;
   logic zdiv_ff;

   // response register
   logic           out_printed_ff;
   logic [Q_W-1:0] out_value_ff;
   logic           out_full_ff;
   logic           out_empty_ff;
   logic           out_zdiv_ff;
   logic           out_unknown_ff;
   logic           out_sat_ff;

   // arithmetic
   logic [Q_W:0]            sum;
   logic signed [2*Q_W-1:0] prod_full;
   sat_type                 sum_sat;
   sat_type                 mul_sat;
   sat_type                 div_sat;
   logic [Q_W-1:0]          a_mag;
   logic [Q_W-1:0]          b_mag;
   logic [DIV_W-1:0]        dividend;
   logic                    div_done;
   logic [DIV_W-1:0]        quotient;
   logic [Q_W-1:0]          remainder;
   logic [DIV_W:0]          quo_signed;
   logic [Q_W:0]            rem_signed;

   assign sp_dec = sp_ff - PTR_W'(1);
   assign popped = pop_hit_ff ? rd_data_ff : '0;

   // stack pointer and memory port
   always_ff @(posedge clock) begin
      if (reset) begin
         sp_ff      <= '0;
         pop_hit_ff <= 1'b0;
      end else if (dp_cmd.pop) begin
         pop_hit_ff <= (sp_ff != '0);
         if (sp_ff != '0) begin
            sp_ff <= sp_dec;
         end
      end else if (dp_cmd.push && (sp_ff != PTR_W'(STACK_DEPTH))) begin
         sp_ff <= sp_ff + PTR_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.push && (sp_ff != PTR_W'(STACK_DEPTH))) begin
         stack_mem[sp_ff[IDX_W-1:0]] <= res_ff;
      end
      if (dp_cmd.pop) begin
         rd_data_ff <= stack_mem[sp_dec[IDX_W-1:0]];
      end
   end

   // add or subtract, then clamp
   assign sum     = (dp_cmd.op == CMD_SUB)
                    ? ({a_ff[Q_W-1], a_ff} - {b_ff[Q_W-1], b_ff})
                    : ({a_ff[Q_W-1], a_ff} + {b_ff[Q_W-1], b_ff});
   assign sum_sat = sat_q({{(DIV_W-Q_W){sum[Q_W]}}, sum});

   // full signed product of the two operands
   assign prod_full = $signed(a_ff) * $signed(b_ff);

   // product shifted right by the fraction bits rounds toward minus infinity
   assign mul_sat = sat_q({prod_ff[2*Q_W-1], prod_ff[2*Q_W-1:FRAC_W]});

   // magnitudes for the unsigned divider
   assign a_mag    = a_ff[Q_W-1] ? (Q_W'(0) - a_ff) : a_ff;
   assign b_mag    = b_ff[Q_W-1] ? (Q_W'(0) - b_ff) : b_ff;
   assign dividend = (dp_cmd.op == CMD_DIV) ? {a_mag, {FRAC_W{1'b0}}}
                                            : {{FRAC_W{1'b0}}, a_mag};

   rpn_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (dp_cmd.div_start),
      .dividend  (dividend),
      .divisor   (b_mag),
      .done      (div_done),
      .quotient  (quotient),
      .remainder (remainder)
   );

   // quotient truncates toward zero; remainder takes the dividend's sign
   assign quo_signed = (a_ff[Q_W-1] ^ b_ff[Q_W-1]) ? ((DIV_W+1)'(0) - {1'b0, quotient})
                                                  : {1'b0, quotient};
   assign div_sat    = sat_q(quo_signed);
   assign rem_signed = a_ff[Q_W-1] ? ((Q_W+1)'(0) - {1'b0, remainder})
                                   : {1'b0, remainder};

   // operands, results and flags
   always_ff @(posedge clock) begin
      if (dp_cmd.load) begin
         res_ff   <= req_operand_value;
         full_ff  <= 1'b0;
         empty_ff <= 1'b0;
         sat_ff   <= 1'b0;
         zdiv_ff  <= 1'b0;
      end
      if (dp_cmd.push && (sp_ff == PTR_W'(STACK_DEPTH))) begin
         full_ff <= 1'b1;
      end
      if (dp_cmd.pop && (sp_ff == '0)) begin
         empty_ff <= 1'b1;
      end
      if (dp_cmd.cap_b) begin
         b_ff <= popped;
      end
      if (dp_cmd.cap_a) begin
         a_ff <= popped;
      end
      if (dp_cmd.exec) begin
         if (dp_cmd.op == CMD_MUL) begin
            prod_ff <= prod_full;
         end else begin
            res_ff <= sum_sat.val;
            if (sum_sat.ovf) begin
               sat_ff <= 1'b1;
            end
         end
      end
      if (dp_cmd.mul_fix) begin
         res_ff <= mul_sat.val;
         if (mul_sat.ovf) begin
            sat_ff <= 1'b1;
         end
      end
      if (dp_cmd.div_fix) begin
         if (dp_cmd.op == CMD_DIV) begin
            res_ff <= div_sat.val;
            if (div_sat.ovf) begin
               sat_ff <= 1'b1;
            end
         end else begin
            res_ff <= rem_signed[Q_W-1:0];
         end
      end
      if (dp_cmd.set_zdiv) begin
         zdiv_ff <= 1'b1;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (dp_cmd.emit) begin
         out_printed_ff <= (dp_cmd.op == CMD_PRINT);
         out_value_ff   <= (dp_cmd.op == CMD_PRINT) ? b_ff : '0;
         out_full_ff    <= full_ff;
         out_empty_ff   <= empty_ff;
         out_zdiv_ff    <= zdiv_ff;
         out_unknown_ff <= (dp_cmd.op == CMD_UNKNOWN);
         out_sat_ff     <= sat_ff;
      end
   end

   assign dp_stat.b_next_zero = (popped == '0);
   assign dp_stat.b_zero      = (b_ff == '0);
   assign dp_stat.div_done    = div_done;

   assign rsp_printed               = out_printed_ff;
   assign rsp_print_value           = out_value_ff;
   assign rsp_stack_full_error      = out_full_ff;
   assign rsp_stack_empty_error     = out_empty_ff;
   assign rsp_zero_divisor_error    = out_zdiv_ff;
   assign rsp_unknown_command_error = out_unknown_ff;
   assign rsp_overflow_saturated    = out_sat_ff;

endmodule

`default_nettype wire

/* rtl/rpn_ctrl.sv */
// Controller: sequences each request through pops, arithmetic, push and response.
`default_nettype none

module rpn_ctrl (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire logic [rpn_pkg::CMD_W-1:0]   req_command,
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output rpn_pkg::dp_cmd_type              dp_cmd,
   input  wire rpn_pkg::dp_stat_type        dp_stat
);
   import rpn_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PUSH,
      ST_POP_B,
      ST_GET_B,
      ST_POP_A,
      ST_GET_A,
      ST_EXEC,
      ST_MUL_FIX,
      ST_DIV_RUN,
      ST_DIV_FIX,
      ST_FINISH
   } state_type;

   state_type state_ff;
   state_type state_in;
   cmd_type   op_ff;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   logic      accept;
   logic      out_free;

   assign req_stall = reset || (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // next state and datapath commands
   always_comb begin
      state_in  = state_ff;
      dp_cmd    = '0;
      dp_cmd.op = op_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               dp_cmd.load = 1'b1;
               case (cmd_type'(req_command))
                  CMD_PUSH:    state_in = ST_PUSH;
                  CMD_UNKNOWN: state_in = ST_FINISH;
                  default:     state_in = ST_POP_B;
               endcase
            end
         end
         ST_PUSH: begin
            dp_cmd.push = 1'b1;
            state_in    = ST_FINISH;
         end
         ST_POP_B: begin
            dp_cmd.pop = 1'b1;
            state_in   = ST_GET_B;
         end
         ST_GET_B: begin
            dp_cmd.cap_b = 1'b1;
            if (op_ff == CMD_PRINT) begin
               state_in = ST_FINISH;
            end else if ((op_ff == CMD_DIV) && dp_stat.b_next_zero) begin
               // divide by zero leaves the dividend on the stack
               dp_cmd.set_zdiv = 1'b1;
               state_in        = ST_FINISH;
            end else begin
               state_in = ST_POP_A;
            end
         end
         ST_POP_A: begin
            dp_cmd.pop = 1'b1;
            state_in   = ST_GET_A;
         end
         ST_GET_A: begin
            dp_cmd.cap_a = 1'b1;
            state_in     = ST_EXEC;
         end
         ST_EXEC: begin
            case (op_ff)
               CMD_ADD, CMD_SUB: begin
                  dp_cmd.exec = 1'b1;
                  state_in    = ST_PUSH;
               end
               CMD_MUL: begin
                  dp_cmd.exec = 1'b1;
                  state_in    = ST_MUL_FIX;
               end
               CMD_REM: begin
                  // remainder by zero has already popped both operands
                  if (dp_stat.b_zero) begin
                     dp_cmd.set_zdiv = 1'b1;
                     state_in        = ST_FINISH;
                  end else begin
                     dp_cmd.div_start = 1'b1;
                     state_in         = ST_DIV_RUN;
                  end
               end
               default: begin
                  dp_cmd.div_start = 1'b1;
                  state_in         = ST_DIV_RUN;
               end
            endcase
         end
         ST_MUL_FIX: begin
            dp_cmd.mul_fix = 1'b1;
            state_in       = ST_PUSH;
         end
         ST_DIV_RUN: begin
            if (dp_stat.div_done) begin
               state_in = ST_DIV_FIX;
            end
         end
         ST_DIV_FIX: begin
            dp_cmd.div_fix = 1'b1;
            state_in       = ST_PUSH;
         end
         ST_FINISH: begin
            if (out_free) begin
               dp_cmd.emit = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // response valid: set on emit, cleared once taken
   always_comb begin
      if (dp_cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         op_ff        <= CMD_PUSH;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            op_ff <= cmd_type'(req_command);
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

/* rtl/rpn_stack_evaluator.sv */
// Top level of the reverse Polish notation stack evaluator on Q16.16 values.
//
// Requests enter on req_valid/req_stall carrying a command (push, add, subtract,
// multiply, divide, remainder, print, unknown) and a Q16.16 operand used by push.
// Every request gives exactly one response on rsp_valid/rsp_stall with the
// printed value and the error flags. A transfer happens on a clock edge with
// valid high and stall low.
// One request is processed at a time; req_stall is high from acceptance until
// the response is loaded into the output register. Divide and remainder wait
// on the one-bit-a-step divider, which runs 48 iterations; a zero divisor ends
// divide after the divisor pop and remainder after both pops.
// Stack accesses go through one memory port with a registered read, so each
// pop takes a pop state and a capture state. The next request can be taken in
// the cycle after the response is loaded.
// A new request is taken while the previous response still waits in the output
// register; if the receiver stalls, the next response waits in the controller
// until that register is free.
// Synchronous reset empties the stack and drops any pending response; stack
// contents are not cleared and need no sweep.
`default_nettype none

module rpn_stack_evaluator #(
   parameter int STACK_DEPTH = 128
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire logic [rpn_pkg::CMD_W-1:0]   req_command,
   input  wire logic [rpn_pkg::Q_W-1:0]     req_operand_value,
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output logic                             rsp_printed,
   output logic [rpn_pkg::Q_W-1:0]          rsp_print_value,
   output logic                             rsp_stack_full_error,
   output logic                             rsp_stack_empty_error,
   output logic                             rsp_zero_divisor_error,
   output logic                             rsp_unknown_command_error,
   output logic                             rsp_overflow_saturated
);
   import rpn_pkg::*;

   dp_cmd_type  dp_cmd;
   dp_stat_type dp_stat;

   rpn_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_command (req_command),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .dp_cmd      (dp_cmd),
      .dp_stat     (dp_stat)
   );

   rpn_dpath #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_dpath (
      .clock                     (clock),
      .reset                     (reset),
      .dp_cmd                    (dp_cmd),
      .dp_stat                   (dp_stat),
      .req_operand_value         (req_operand_value),
      .rsp_printed               (rsp_printed),
      .rsp_print_value           (rsp_print_value),
      .rsp_stack_full_error      (rsp_stack_full_error),
      .rsp_stack_empty_error     (rsp_stack_empty_error),
      .rsp_zero_divisor_error    (rsp_zero_divisor_error),
      .rsp_unknown_command_error (rsp_unknown_command_error),
      .rsp_overflow_saturated    (rsp_overflow_saturated)
   );

   // the divider is never launched on a zero divisor
   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      dp_cmd.div_start |-> !dp_stat.b_zero)
      else $error("divider started with zero divisor");

   // one stack access per cycle
   a_push_pop_excl: assert property (@(posedge clock) disable iff (reset)
      !(dp_cmd.push && dp_cmd.pop))
      else $error("push and pop in the same cycle");

   // a new response never overwrites one still waiting
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      dp_cmd.emit |-> (!rsp_valid || !rsp_stall))
      else $error("response overwritten while stalled");

   // an accepted request holds off the next one
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request accepted while busy");

endmodule

`default_nettype wire
